FILE: sv/tes_pkg.sv
// Shared constants and types for the text encoding sniffer.
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

	// Lead positions scanned before the UTF-8 scan gives up.
	localparam int MAX_LOOKUP = 16384;
	localparam int SCAN_CNT_W = $clog2(MAX_LOOKUP + 1);

	localparam int BYTE_W    = 8;
	localparam int CP_W      = 16;
	localparam int VERDICT_W = 4;
	localparam int OUT_W     = VERDICT_W + CP_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int PREFIX_LEN = 6;
	localparam int SEEN_W    = 3;

	typedef logic [VERDICT_W-1:0] verdict_t;
	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [CP_W-1:0]      code_page_t;

	localparam verdict_t V_UTF8_BOM  = 4'd0;
	localparam verdict_t V_U16LE_BOM = 4'd1;
	localparam verdict_t V_U16BE_BOM = 4'd2;
	localparam verdict_t V_U16LE     = 4'd3;
	localparam verdict_t V_U16BE     = 4'd4;
	localparam verdict_t V_ISO885915 = 4'd5;
	localparam verdict_t V_OEM       = 4'd6;
	localparam verdict_t V_ANSI      = 4'd7;
	localparam verdict_t V_UTF8      = 4'd8;
	localparam verdict_t V_DEFAULT   = 4'd9;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_DEFAULT_CP = 2'd0;
	localparam logic [1:0] REG_ANSI_CP    = 2'd1;
	localparam logic [1:0] REG_OEM_CP     = 2'd2;

	localparam byte_t B_BOM8_0    = 8'hEF;
	localparam byte_t B_BOM8_1    = 8'hBB;
	localparam byte_t B_BOM8_2    = 8'hBF;
	localparam byte_t B_FF        = 8'hFF;
	localparam byte_t B_FE        = 8'hFE;
	localparam byte_t B_EURO      = 8'd164;
	localparam byte_t B_QUOTE     = 8'd146;
	localparam byte_t B_OEM_TOP   = 8'hA0;
	localparam byte_t B_CONT_MASK = 8'hC0;
	localparam byte_t B_CONT_TAG  = 8'h80;
	localparam byte_t B_LEAD2     = 8'hC0;
	localparam byte_t B_LEAD3     = 8'hE0;
	localparam byte_t B_LEAD4     = 8'hF0;
	localparam byte_t B_BAD_LEAD  = 8'd248;

endpackage

`default_nettype wire

FILE: sv/tes_scan.sv
// UTF-8 scan state: tracks leads, continuations and the first deciding byte.
`timescale 1ns / 1ps
`default_nettype none

module tes_scan (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  tes_pkg::byte_t      byte_in,
	input  wire                 last_in,
	output tes_pkg::verdict_t   scan_verdict
);

	logic                          done_q, done_n;
	tes_pkg::verdict_t             verd_q, verd_n;
	logic [1:0]                    pend_q, pend_n;
	logic                          mbs_q, mbs_n;
	logic [tes_pkg::SCAN_CNT_W-1:0] cnt_q, cnt_n;

	always_comb begin
		done_n = done_q;
		verd_n = verd_q;
		pend_n = pend_q;
		mbs_n  = mbs_q;
		cnt_n  = cnt_q;
		if (!done_q) begin
			if (pend_q != 2'd0) begin
				if ((byte_in & tes_pkg::B_CONT_MASK) == tes_pkg::B_CONT_TAG) begin
					pend_n = pend_q - 2'd1;
					if (pend_q == 2'd1) begin
						mbs_n = 1'b1;
					end
				end else begin
					done_n = 1'b1;
					verd_n = tes_pkg::V_ANSI;
				end
			end else if (cnt_q >= tes_pkg::SCAN_CNT_W'(tes_pkg::MAX_LOOKUP)
					|| byte_in == '0) begin
				done_n = 1'b1;
				verd_n = mbs_q ? tes_pkg::V_UTF8 : tes_pkg::V_DEFAULT;
			end else begin
				cnt_n = cnt_q + tes_pkg::SCAN_CNT_W'(1);
				priority if (byte_in < tes_pkg::B_CONT_TAG) begin
					// plain ASCII, keep going
				end else if (byte_in == tes_pkg::B_EURO) begin
					done_n = 1'b1;
					verd_n = tes_pkg::V_ISO885915;
				end else if (byte_in <= tes_pkg::B_OEM_TOP && byte_in != tes_pkg::B_QUOTE) begin
					done_n = 1'b1;
					verd_n = tes_pkg::V_OEM;
				end else if (byte_in < tes_pkg::B_LEAD2 || byte_in >= tes_pkg::B_BAD_LEAD) begin
					done_n = 1'b1;
					verd_n = tes_pkg::V_ANSI;
				end else if (byte_in >= tes_pkg::B_LEAD4) begin
					pend_n = 2'd3;
				end else if (byte_in >= tes_pkg::B_LEAD3) begin
					pend_n = 2'd2;
				end else begin
					pend_n = 2'd1;
				end
			end
		end
	end

	// verdict as it stands if this byte ends the buffer; truncation is a failure
	always_comb begin
		priority if (done_n) begin
			scan_verdict = verd_n;
		end else if (pend_n != 2'd0) begin
			scan_verdict = tes_pkg::V_ANSI;
		end else begin
			scan_verdict = mbs_n ? tes_pkg::V_UTF8 : tes_pkg::V_DEFAULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			verd_q <= tes_pkg::V_DEFAULT;
			pend_q <= 2'd0;
			mbs_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (step) begin
			if (last_in) begin
				done_q <= 1'b0;
				verd_q <= tes_pkg::V_DEFAULT;
				pend_q <= 2'd0;
				mbs_q  <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= done_n;
				verd_q <= verd_n;
				pend_q <= pend_n;
				mbs_q  <= mbs_n;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/text_encoding_sniffer_unit.sv
// Top level of the text encoding sniffer: stream ports, registers, prefix checks.
//
// Usage: a buffer streams in one byte per item on the s_ side, tlast on its
// last byte. Only the last byte produces a result on the m_ side: the verdict
// and the code page picked for it (zero unless the verdict is oem, ansi or
// default). BOM and UTF-16 zero patterns in the first six bytes take priority
// over the UTF-8 scan, which stops at the first deciding byte or after
// MAX_LOOKUP lead bytes.
// Throughput: one byte per cycle across buffers, while no final byte waits on m_tready.
// Result path: the last byte is registered in the input register, then its
// verdict and code page in the result register, once that register is free.
// Stall: the result register holds until m_tready; meanwhile non-final bytes
// still flow, and a final byte waits in the input register, dropping s_tready.
// Reset: the three code page registers clear to zero, per-buffer scan and prefix
// state to its start; that per-buffer state also clears after each final byte.
// Config: APB, registers at 0x0 default, 0x4 ansi, 0x8 oem code page (16 bits);
// the user writes them only while no buffer is in flight (the block does not enforce this).
`timescale 1ns / 1ps
`default_nettype none

module text_encoding_sniffer_unit (
	input  wire         clk,
	input  wire         arst_n,
	// stream in
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] text_byte
	input  wire         s_tlast,   // is_final
	// stream out
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [tes_pkg::OUT_TDATA_W-1:0] m_tdata, // [3:0] verdict, [19:4] chosen_code_page
	// APB config
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tes_pkg::code_page_t default_cp_q, ansi_cp_q, oem_cp_q;

	logic                valid_s1;
	tes_pkg::byte_t      byte_s1;
	logic                last_s1;
	logic                advance;
	logic                step;

	tes_pkg::byte_t                 prefix_q [tes_pkg::PREFIX_LEN];
	tes_pkg::byte_t                 prefix_n [tes_pkg::PREFIX_LEN];
	logic [tes_pkg::SEEN_W-1:0]     seen_q, seen_n;

	tes_pkg::verdict_t   scan_verdict;
	tes_pkg::verdict_t   verdict;
	tes_pkg::code_page_t chosen_cp;

	logic                                 m_tvalid_q;
	logic [tes_pkg::OUT_TDATA_W-1:0]      m_tdata_q;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_cp_q <= '0;
			ansi_cp_q    <= '0;
			oem_cp_q     <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				tes_pkg::REG_DEFAULT_CP: default_cp_q <= pwdata[15:0];
				tes_pkg::REG_ANSI_CP:    ansi_cp_q    <= pwdata[15:0];
				tes_pkg::REG_OEM_CP:     oem_cp_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			tes_pkg::REG_DEFAULT_CP: prdata = {16'd0, default_cp_q};
			tes_pkg::REG_ANSI_CP:    prdata = {16'd0, ansi_cp_q};
			tes_pkg::REG_OEM_CP:     prdata = {16'd0, oem_cp_q};
			default:                 prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// non-final bytes never need the result register
	assign advance  = !last_s1 || !m_tvalid_q || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// ---------------- prefix capture ----------------
	always_comb begin
		for (int i = 0; i < tes_pkg::PREFIX_LEN; i++) begin
			prefix_n[i] = (seen_q == tes_pkg::SEEN_W'(i)) ? byte_s1 : prefix_q[i];
		end
		seen_n = (seen_q < tes_pkg::SEEN_W'(tes_pkg::PREFIX_LEN))
			? seen_q + tes_pkg::SEEN_W'(1) : seen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (step) begin
			seen_q <= last_s1 ? '0 : seen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < tes_pkg::PREFIX_LEN; i++) begin
				prefix_q[i] <= prefix_n[i];
			end
		end
	end

	// ---------------- UTF-8 scan ----------------
	tes_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.byte_in      (byte_s1),
		.last_in      (last_s1),
		.scan_verdict (scan_verdict)
	);

	// ---------------- final decision ----------------
	always_comb begin
		priority if (seen_n >= 3'd3 && prefix_n[0] == tes_pkg::B_BOM8_0
				&& prefix_n[1] == tes_pkg::B_BOM8_1 && prefix_n[2] == tes_pkg::B_BOM8_2) begin
			verdict = tes_pkg::V_UTF8_BOM;
		end else if (seen_n >= 3'd2 && prefix_n[0] == tes_pkg::B_FF
				&& prefix_n[1] == tes_pkg::B_FE) begin
			verdict = tes_pkg::V_U16LE_BOM;
		end else if (seen_n >= 3'd2 && prefix_n[0] == tes_pkg::B_FE
				&& prefix_n[1] == tes_pkg::B_FF) begin
			verdict = tes_pkg::V_U16BE_BOM;
		end else if (seen_n >= 3'd6 && prefix_n[1] == '0 && prefix_n[3] == '0
				&& prefix_n[5] == '0) begin
			verdict = tes_pkg::V_U16LE;
		end else if (seen_n >= 3'd6 && prefix_n[0] == '0 && prefix_n[2] == '0
				&& prefix_n[4] == '0) begin
			verdict = tes_pkg::V_U16BE;
		end else begin
			verdict = scan_verdict;
		end
	end

	always_comb begin
		priority if (verdict == tes_pkg::V_OEM) begin
			chosen_cp = oem_cp_q;
		end else if (verdict == tes_pkg::V_ANSI) begin
			chosen_cp = ansi_cp_q;
		end else if (verdict == tes_pkg::V_DEFAULT) begin
			chosen_cp = default_cp_q;
		end else begin
			chosen_cp = '0;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			m_tdata_q <= tes_pkg::OUT_TDATA_W'({chosen_cp, verdict});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: sim/text_encoding_sniffer_unit_test.sv
// Self-checking testbench for the text encoding sniffer: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 1ps

// Tracks the per-buffer sniffing state and queues the verdict expected on each final byte.
class sniff_scoreboard;
	tes_pkg::code_page_t cp_default, cp_ansi, cp_oem;
	tes_pkg::byte_t head[6];
	int unsigned head_len;
	int unsigned lead_count;
	int unsigned owed;
	bit decided;
	tes_pkg::verdict_t scan_v;
	bit multi_done;
	tes_pkg::verdict_t exp_verdict[$];
	tes_pkg::code_page_t exp_cp[$];
	int errors;

	function new();
		cp_default = '0;
		cp_ansi = '0;
		cp_oem = '0;
		errors = 0;
		clear_buffer();
	endfunction

	function void clear_buffer();
		foreach (head[i]) head[i] = '0;
		head_len = 0;
		lead_count = 0;
		owed = 0;
		decided = 1'b0;
		scan_v = tes_pkg::V_DEFAULT;
		multi_done = 1'b0;
	endfunction

	function void set_reg(logic [1:0] idx, tes_pkg::code_page_t val);
		case (idx)
			tes_pkg::REG_DEFAULT_CP: cp_default = val;
			tes_pkg::REG_ANSI_CP:    cp_ansi = val;
			tes_pkg::REG_OEM_CP:     cp_oem = val;
			default: ;
		endcase
	endfunction

	function void stop_scan(tes_pkg::verdict_t v);
		decided = 1'b1;
		scan_v = v;
	endfunction

	function void note_byte(tes_pkg::byte_t b, bit is_last);
		tes_pkg::verdict_t v;
		tes_pkg::code_page_t cp;
		if (head_len < 6) begin
			head[head_len] = b;
			head_len++;
		end
		if (!decided) begin
			if (owed != 0) begin
				if ((b & 8'hC0) == 8'h80) begin
					owed--;
					if (owed == 0)
						multi_done = 1'b1;
				end else begin
					stop_scan(tes_pkg::V_ANSI);
				end
			end else if (lead_count >= tes_pkg::MAX_LOOKUP || b == 8'h00) begin
				stop_scan(multi_done ? tes_pkg::V_UTF8 : tes_pkg::V_DEFAULT);
			end else begin
				lead_count++;
				if (b >= 8'h80) begin
					if (b == 8'hA4)
						stop_scan(tes_pkg::V_ISO885915);
					else if (b <= 8'hA0 && b != 8'h92)
						stop_scan(tes_pkg::V_OEM);
					else if (b < 8'hC0 || b >= 8'hF8)
						stop_scan(tes_pkg::V_ANSI);
					else if (b >= 8'hF0)
						owed = 3;
					else if (b >= 8'hE0)
						owed = 2;
					else
						owed = 1;
				end
			end
		end
		if (!is_last)
			return;

		// buffer ended mid-sequence counts as broken UTF-8
		if (!decided)
			scan_v = (owed != 0) ? tes_pkg::V_ANSI :
				(multi_done ? tes_pkg::V_UTF8 : tes_pkg::V_DEFAULT);

		if (head_len >= 3 && head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF)
			v = tes_pkg::V_UTF8_BOM;
		else if (head_len >= 2 && head[0] == 8'hFF && head[1] == 8'hFE)
			v = tes_pkg::V_U16LE_BOM;
		else if (head_len >= 2 && head[0] == 8'hFE && head[1] == 8'hFF)
			v = tes_pkg::V_U16BE_BOM;
		else if (head_len >= 6 && head[1] == 0 && head[3] == 0 && head[5] == 0)
			v = tes_pkg::V_U16LE;
		else if (head_len >= 6 && head[0] == 0 && head[2] == 0 && head[4] == 0)
			v = tes_pkg::V_U16BE;
		else
			v = scan_v;

		case (v)
			tes_pkg::V_OEM:     cp = cp_oem;
			tes_pkg::V_ANSI:    cp = cp_ansi;
			tes_pkg::V_DEFAULT: cp = cp_default;
			default:            cp = '0;
		endcase
		exp_verdict.insert(exp_verdict.size(), v);
		exp_cp.insert(exp_cp.size(), cp);
		clear_buffer();
	endfunction

	function void check_result(logic [tes_pkg::OUT_TDATA_W-1:0] d);
		tes_pkg::verdict_t v, got_v;
		tes_pkg::code_page_t cp, got_cp;
		got_v = d[3:0];
		got_cp = d[19:4];
		if (exp_verdict.size() == 0) begin
			$display("%0t: unexpected result verdict=%0d code_page=%h", $time, got_v, got_cp);
			errors++;
			return;
		end
		v = exp_verdict.pop_front();
		cp = exp_cp.pop_front();
		if (got_v !== v) begin
			$display("%0t: verdict expected %0d actual %0d", $time, v, got_v);
			errors++;
		end
		if (got_cp !== cp) begin
			$display("%0t: code page expected %h actual %h", $time, cp, got_cp);
			errors++;
		end
		if (d[tes_pkg::OUT_TDATA_W-1:20] !== '0) begin
			$display("%0t: pad bits expected 0 actual %h", $time, d[tes_pkg::OUT_TDATA_W-1:20]);
			errors++;
		end
	endfunction

	function int pending();
		return exp_verdict.size();
	endfunction
endclass

module text_encoding_sniffer_unit_test;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 260;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [tes_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sniff_scoreboard sb;
	tes_pkg::byte_t txt[$];
	int items_sent;
	int burst_left;
	bit no_gaps;
	bit hold_req;

	text_encoding_sniffer_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// receiver pacing: randomly chosen stall patterns plus an on-demand long hold-off
	initial begin : rx_pace
		int mode, run, tick;
		mode = 0;
		run = 0;
		tick = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (run == 0) begin
					mode = int'($urandom_range(0, 3));
					run = int'($urandom_range(20, 150));
				end
				run--;
				tick++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (tick % 4 == 0);
					default: m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// watchdog: ends the run after too long with no handshake on any port
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			    (psel && penable && pwrite && pready))
				idle = 0;
			else
				idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// one byte per item; entered and left at a falling edge
	task put_byte(input tes_pkg::byte_t b, input bit is_last);
		if (!no_gaps && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 300 : int'($urandom_range(1, 24));
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, is_last);
		items_sent++;
		@(negedge clk);
	endtask

	task send_text();
		foreach (txt[i])
			put_byte(txt[i], i == txt.size() - 1);
	endtask

	task reg_write(input logic [1:0] idx, input tes_pkg::code_page_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// sender stops until every verdict is back, then lets the pipeline settle
	task wait_drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task add_byte(input tes_pkg::byte_t b);
		txt.insert(txt.size(), b);
	endtask

	task add_cont(input int n);
		repeat (n) add_byte(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	// one well-formed character: mostly ASCII, sometimes a 2, 3 or 4 byte sequence
	task add_char();
		int k;
		k = int'($urandom_range(0, 9));
		if (k < 6) begin
			add_byte(8'($urandom_range(1, 127)));
		end else if (k < 8) begin
			add_byte(8'($urandom_range(8'hC0, 8'hDF)));
			add_cont(1);
		end else if (k < 9) begin
			add_byte(8'($urandom_range(8'hE0, 8'hEF)));
			add_cont(2);
		end else begin
			add_byte(8'($urandom_range(8'hF0, 8'hF7)));
			add_cont(3);
		end
	endtask

	task build_random_text();
		int kind, n;
		bit le;
		tes_pkg::byte_t ch;
		txt.delete();
		kind = int'($urandom_range(0, 99));
		n = int'($urandom_range(1, 20));
		if (kind < 45) begin
			repeat (n) add_char();
		end else if (kind < 60) begin
			// valid text broken by one deciding byte or a bad sequence
			repeat ($urandom_range(0, 8)) add_char();
			case ($urandom_range(0, 7))
				0: add_byte(8'hA4);
				1: add_byte(8'($urandom_range(8'h80, 8'hA0)));
				2: add_byte(8'h92);
				3: add_byte(8'($urandom_range(8'hA1, 8'hBF)));
				4: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
				5: add_byte(8'h00);
				6: begin
					add_byte(8'($urandom_range(8'hC0, 8'hF7)));
					add_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(8'hC0, 8'hFF)));
				end
				default: begin
					add_byte(8'($urandom_range(8'hE0, 8'hF7)));
					add_cont(int'($urandom_range(0, 1)));
				end
			endcase
			if (txt[txt.size() - 1] < 8'hC0)
				repeat ($urandom_range(0, 5)) add_char();
		end else if (kind < 70) begin
			case ($urandom_range(0, 3))
				0: txt = '{8'hEF, 8'hBB, 8'hBF};
				1: txt = '{8'hFF, 8'hFE};
				2: txt = '{8'hFE, 8'hFF};
				default: txt = '{8'hEF, 8'hBB};
			endcase
			repeat ($urandom_range(0, 8)) add_char();
		end else if (kind < 80) begin
			le = 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 8)) begin
				ch = 8'($urandom_range(1, 127));
				if (le) begin
					add_byte(ch);
					add_byte(8'h00);
				end else begin
					add_byte(8'h00);
					add_byte(ch);
				end
			end
			if (txt.size() > 1 && $urandom_range(0, 3) == 0)
				void'(txt.pop_back());
		end else begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task program_regs(input int ph);
		case (ph)
			0: begin
				reg_write(tes_pkg::REG_DEFAULT_CP, 16'hFFFF);
				reg_write(tes_pkg::REG_ANSI_CP, 16'hFFFF);
				reg_write(tes_pkg::REG_OEM_CP, 16'hFFFF);
			end
			2: begin
				reg_write(tes_pkg::REG_DEFAULT_CP, 16'h0000);
				reg_write(tes_pkg::REG_ANSI_CP, 16'hFFFF);
				reg_write(tes_pkg::REG_OEM_CP, 16'($urandom));
			end
			default: begin
				reg_write(tes_pkg::REG_OEM_CP, 16'($urandom));
				reg_write(tes_pkg::REG_DEFAULT_CP, 16'($urandom));
				reg_write(tes_pkg::REG_ANSI_CP, 16'($urandom));
			end
		endcase
	endtask

	initial begin : main
		int ph, target;
		sb = new();
		items_sent = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed buffers, registers still at reset
		txt = '{8'h00}; send_text();
		txt = '{8'hEF, 8'hBB, 8'hBF}; send_text();
		txt = '{8'hFF, 8'hFE}; send_text();
		txt = '{8'hFE, 8'hFF}; send_text();
		txt = '{8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00}; send_text();
		txt = '{8'h00, 8'h41, 8'h00, 8'h42, 8'h00, 8'h43}; send_text();
		txt = '{8'hA4}; send_text();
		txt = '{8'h80}; send_text();
		txt = '{8'h92}; send_text();
		txt = '{8'hC3, 8'hA9}; send_text();
		txt = '{8'hE2, 8'h82}; send_text();
		txt = '{8'hFF}; send_text();

		target = items_sent;
		for (ph = 0; ph < 4; ph++) begin
			wait_drain();
			program_regs(ph);
			if (ph == 2) begin
				// long output stall while short buffers keep coming
				hold_req = 1'b1;
				no_gaps = 1'b1;
				repeat (24) put_byte(8'($urandom_range(0, 255)), 1'b1);
				no_gaps = 1'b0;
			end
			target += PHASE_ITEMS;
			while (items_sent < target) begin
				build_random_text();
				send_text();
			end
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
